### rtl/i2cms_pkg.sv
// i2cms_pkg: shared constants and types for the I2C master status sequencer.
// No dependencies; imported by every module of the block.
package i2cms_pkg;

    // Transfer buffer geometry
    localparam int BUFFER_DEPTH = 32;
    localparam int ADDR_W       = $clog2(BUFFER_DEPTH);
    localparam int POS_W        = 5;
    localparam int LEN_W        = 5;

    // Commands
    localparam logic [1:0] CMD_LOAD  = 2'd0;
    localparam logic [1:0] CMD_READ  = 2'd1;
    localparam logic [1:0] CMD_BEGIN = 2'd2;
    localparam logic [1:0] CMD_EVENT = 2'd3;

    // Controller status codes
    localparam logic [7:0] SC_START      = 8'h08;
    localparam logic [7:0] SC_RESTART    = 8'h10;
    localparam logic [7:0] SC_SLA_W_ACK  = 8'h18;
    localparam logic [7:0] SC_SLA_W_NACK = 8'h20;
    localparam logic [7:0] SC_DATA_ACK   = 8'h28;
    localparam logic [7:0] SC_DATA_NACK  = 8'h30;
    localparam logic [7:0] SC_ARB_LOST   = 8'h38;
    localparam logic [7:0] SC_SLA_R_ACK  = 8'h40;
    localparam logic [7:0] SC_SLA_R_NACK = 8'h48;
    localparam logic [7:0] SC_RX_ACK     = 8'h50;
    localparam logic [7:0] SC_RX_NACK    = 8'h58;

    // Transfer states
    localparam logic [2:0] ST_IDLE           = 3'd0;
    localparam logic [2:0] ST_STARTED        = 3'd1;
    localparam logic [2:0] ST_RESTARTED      = 3'd2;
    localparam logic [2:0] ST_REPEATED_START = 3'd3;
    localparam logic [2:0] ST_DATA_ACK       = 3'd4;
    localparam logic [2:0] ST_DONE           = 3'd5;

    // Register indexes on the configuration port
    localparam logic REG_WRITE_LENGTH = 1'b0;
    localparam logic REG_READ_LENGTH  = 1'b1;

    // Decoded request after the first stage; the byte comes from the buffer
    typedef struct packed {
        logic       transmit_valid;
        logic       read_request;
        logic       set_start;
        logic       set_stop;
        logic       set_ack;
        logic       clear_start;
        logic       clear_interrupt;
        logic [2:0] transfer_state;
    } t_s1;

endpackage

### rtl/i2c_master_status_sequencer_core.sv
// i2c_master_status_sequencer_core: top level with configuration registers,
// handshake and result register. Depends on i2cms_pkg and i2cms_seq.
//
// Usage: software loads the 32-byte transfer buffer with load requests
// (slot 0 address+write, slots 1.. write data, slot 2 address+read), sets
// write_length and read_length over the APB port (offsets 0x0 and 0x4),
// then sends begin. Every controller status code is then sent as a status
// event request; each request yields exactly one result carrying the byte
// to transmit, the control actions and the transfer state.
// Input channel: i_valid / o_stall. Output channel: o_valid / i_stall.
// The decode and buffer read are registered in the first stage, then the
// result register. Unless o_stall is high, one request is taken per cycle.
// If the receiver stalls, the result register and the first stage hold and
// o_stall rises once both are full; nothing is dropped.
// Reset clears the transfer state, positions, lengths and valid flags; the
// buffer contents are undefined until loaded.
module i2c_master_status_sequencer_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [1:0]  i_command,
    input  logic [7:0]  i_status_code,
    input  logic [7:0]  i_received_byte,
    input  logic [4:0]  i_buffer_index,
    input  logic [7:0]  i_buffer_value,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_transmit_byte,
    output logic        o_transmit_valid,
    output logic        o_set_start,
    output logic        o_set_stop,
    output logic        o_set_ack,
    output logic        o_clear_start,
    output logic        o_clear_interrupt,
    output logic [2:0]  o_transfer_state,
    output logic [7:0]  o_read_value,
    output logic        o_transfer_done,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import i2cms_pkg::*;

    logic [LEN_W-1:0] r_write_length;
    logic [LEN_W-1:0] r_read_length;
    logic             cfg_write;
    logic             accept;
    logic             s1_move;
    logic             r_s1_valid;
    logic             r_out_valid;
    t_s1              s1;
    logic [7:0]       buf_data;
    logic [7:0]       r_tx;
    logic [7:0]       r_rd;
    t_s1              r_out;

    // Configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_write_length <= '0;
            r_read_length  <= '0;
        end else if (cfg_write) begin
            if (paddr[2] == REG_WRITE_LENGTH) begin
                r_write_length <= pwdata[LEN_W-1:0];
            end else begin
                r_read_length <= pwdata[LEN_W-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == REG_WRITE_LENGTH) ? 32'(r_write_length)
                                                   : 32'(r_read_length);

    // Handshake: first stage drains into the result register when it is free
    assign s1_move = r_s1_valid && (!r_out_valid || !i_stall);
    assign o_stall = r_s1_valid && !s1_move;
    assign accept  = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    i2cms_seq u_seq (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (accept),
        .i_command       (i_command),
        .i_status_code   (i_status_code),
        .i_received_byte (i_received_byte),
        .i_buffer_index  (i_buffer_index),
        .i_buffer_value  (i_buffer_value),
        .i_write_length  (r_write_length),
        .i_read_length   (r_read_length),
        .o_s1            (s1),
        .o_buf_data      (buf_data)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= s1;
            r_tx  <= s1.transmit_valid ? buf_data : 8'd0;
            r_rd  <= s1.read_request ? buf_data : 8'd0;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_transmit_byte   = r_tx;
    assign o_transmit_valid  = r_out.transmit_valid;
    assign o_set_start       = r_out.set_start;
    assign o_set_stop        = r_out.set_stop;
    assign o_set_ack         = r_out.set_ack;
    assign o_clear_start     = r_out.clear_start;
    assign o_clear_interrupt = r_out.clear_interrupt;
    assign o_transfer_state  = r_out.transfer_state;
    assign o_read_value      = r_rd;
    assign o_transfer_done   = (r_out.transfer_state == ST_DONE);

endmodule

### rtl/i2cms_seq.sv
// i2cms_seq: decodes one request, updates transfer state and positions, and
// accesses the transfer buffer. Depends on i2cms_pkg.
module i2cms_seq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  logic [1:0]                 i_command,
    input  logic [7:0]                 i_status_code,
    input  logic [7:0]                 i_received_byte,
    input  logic [4:0]                 i_buffer_index,
    input  logic [7:0]                 i_buffer_value,
    input  logic [i2cms_pkg::LEN_W-1:0] i_write_length,
    input  logic [i2cms_pkg::LEN_W-1:0] i_read_length,
    output i2cms_pkg::t_s1             o_s1,
    output logic [7:0]                 o_buf_data
);
    import i2cms_pkg::*;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [POS_W-1:0]  r_wpos;
    logic [POS_W-1:0]  n_wpos;
    logic [POS_W-1:0]  r_rpos;
    logic [POS_W-1:0]  n_rpos;
    logic [POS_W-1:0]  wpos_inc;
    logic [POS_W-1:0]  rpos_inc;
    logic [POS_W-1:0]  wr_slot;
    logic [POS_W-1:0]  rx_slot;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_we;
    logic [7:0]        mem_wdata;
    t_s1               n_s1;
    t_s1               r_s1;
    logic [7:0]        r_rdata;
    logic [7:0]        r_mem [BUFFER_DEPTH];

    assign wpos_inc = r_wpos + POS_W'(1);
    assign rpos_inc = r_rpos + POS_W'(1);
    assign wr_slot  = r_wpos + POS_W'(1);
    assign rx_slot  = r_rpos + POS_W'(3);

    // Request decode and next transfer state
    always_comb begin
        n_state   = r_state;
        n_wpos    = r_wpos;
        n_rpos    = r_rpos;
        n_s1      = '0;
        mem_addr  = ADDR_W'(i_buffer_index);
        mem_we    = 1'b0;
        mem_wdata = i_buffer_value;
        unique case (i_command)
            CMD_LOAD: begin
                mem_we = 1'b1;
            end
            CMD_READ: begin
                n_s1.read_request = 1'b1;
            end
            CMD_BEGIN: begin
                n_state        = ST_IDLE;
                n_wpos         = '0;
                n_rpos         = '0;
                n_s1.set_start = 1'b1;
            end
            default: begin
                n_s1.clear_interrupt = 1'b1;
                unique case (i_status_code)
                    SC_START: begin
                        mem_addr            = ADDR_W'(0);
                        n_s1.transmit_valid = 1'b1;
                        n_s1.clear_start    = 1'b1;
                        n_state             = ST_STARTED;
                    end
                    SC_RESTART: begin
                        mem_addr            = ADDR_W'(2);
                        n_s1.transmit_valid = 1'b1;
                        n_s1.clear_start    = 1'b1;
                        n_state             = ST_RESTARTED;
                    end
                    SC_SLA_W_ACK: begin
                        if (r_state == ST_STARTED) begin
                            mem_addr            = ADDR_W'(wr_slot);
                            n_s1.transmit_valid = 1'b1;
                            n_wpos              = wpos_inc;
                            n_state             = ST_DATA_ACK;
                        end
                    end
                    SC_SLA_W_NACK, SC_DATA_ACK, SC_DATA_NACK: begin
                        if (r_wpos != i_write_length) begin
                            mem_addr            = ADDR_W'(wr_slot);
                            n_s1.transmit_valid = 1'b1;
                            n_wpos              = wpos_inc;
                            if (wpos_inc != i_write_length) begin
                                n_state = ST_DATA_ACK;
                            end else if (i_read_length != '0) begin
                                n_s1.set_start = 1'b1;
                                n_state        = ST_REPEATED_START;
                            end else begin
                                n_state = ST_DONE;
                            end
                        end else if (i_read_length != '0) begin
                            n_s1.set_start = 1'b1;
                            n_state        = ST_REPEATED_START;
                        end else begin
                            n_s1.set_stop = 1'b1;
                            n_state       = ST_DONE;
                        end
                    end
                    SC_ARB_LOST, SC_SLA_R_ACK: begin
                        n_s1.set_ack = 1'b1;
                    end
                    SC_SLA_R_NACK: begin
                        n_state = ST_DONE;
                    end
                    SC_RX_ACK, SC_RX_NACK: begin
                        // store the received byte from slot 3 on
                        mem_addr     = ADDR_W'(rx_slot);
                        mem_we       = 1'b1;
                        mem_wdata    = i_received_byte;
                        n_s1.set_ack = 1'b1;
                        if (rpos_inc != i_read_length) begin
                            n_rpos  = rpos_inc;
                            n_state = ST_DATA_ACK;
                        end else begin
                            n_rpos  = '0;
                            n_state = ST_DONE;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase
        n_s1.transfer_state = n_state;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wpos  <= '0;
            r_rpos  <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
            r_wpos  <= n_wpos;
            r_rpos  <= n_rpos;
        end
    end

    // Stage payload
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_s1 <= n_s1;
        end
    end

    // Transfer buffer, one port, registered read
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (mem_we) begin
                r_mem[mem_addr] <= mem_wdata;
            end
            r_rdata <= r_mem[mem_addr];
        end
    end

    assign o_s1       = r_s1;
    assign o_buf_data = r_rdata;

endmodule

### rtl/i2cms_chk.sv
// i2cms_chk: port-level checks for the sequencer core, bound to the top level.
// Depends on i2cms_pkg and i2c_master_status_sequencer_core.
module i2cms_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_stall,
    input logic [7:0] o_transmit_byte,
    input logic       o_transmit_valid,
    input logic       o_set_start,
    input logic       o_set_stop,
    input logic [2:0] o_transfer_state,
    input logic       o_transfer_done
);
    import i2cms_pkg::*;

    // No result shows right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // Done flag follows the reported state
    a_done_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_transfer_done == (o_transfer_state == ST_DONE)))
        else $error("done flag disagrees with state");

    // Transmit byte is zero unless it is to be loaded
    a_tx_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_transmit_valid) |-> (o_transmit_byte == 8'd0))
        else $error("stray transmit byte");

    // Start and stop are never requested together
    a_start_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_set_start && o_set_stop))
        else $error("start and stop together");

    // A stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_transmit_byte)
                                  && $stable(o_transfer_state)))
        else $error("stalled result changed");

endmodule

bind i2c_master_status_sequencer_core i2cms_chk u_i2cms_chk (.*);
